/* rtl/stsq_pkg.sv */
// ----------------------------------------------------------------------------
// stsq_pkg
// Types, codes and timing tables shared by the step timeout retry sequencer.
// ----------------------------------------------------------------------------
package stsq_pkg;

	localparam int MAX_STEPS = 8;
	localparam int STEP_W    = $clog2(MAX_STEPS);
	localparam int COUNT_W   = 4;
	localparam int LEVELS_W  = 3 * MAX_STEPS;
	localparam int WAIT_W    = 15;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_NET_CONDITION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LEVELS   = 2'd2;

	localparam logic [1:0] NET_COND_MAX = 2'd2;
	localparam logic [2:0] LEVEL_MAX    = 3'd4;

	typedef enum logic [1:0] {
		MODE_START = 2'd0,
		MODE_TICK  = 2'd1,
		MODE_REPLY = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REPLY_JUMP  = 3'd0,
		REPLY_DONE  = 3'd1,
		REPLY_GO_ON = 3'd2,
		REPLY_REDO  = 3'd3,
		REPLY_ABORT = 3'd4
	} reply_kind_t;

	typedef enum logic [1:0] {
		PH_NORMAL   = 2'd0,
		PH_FIRST    = 2'd1,
		PH_OVERTIME = 2'd2,
		PH_LAST     = 2'd3
	} phase_t;

	typedef struct packed {
		logic [1:0]          net_condition;
		logic [COUNT_W-1:0]  step_count;
		logic [LEVELS_W-1:0] step_levels;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] now_ms;
		logic [2:0]  reply_kind;
		logic [6:0]  reply_target;
	} item_t;

	typedef struct packed {
		logic [1:0]        phase;
		logic [STEP_W-1:0] current_step;
		logic              active;
		logic              finished;
		logic              bad_reply;
	} result_t;

	localparam logic [WAIT_W-1:0] WAIT_MS [3][5] = '{
		'{15'd600, 15'd1000, 15'd1500, 15'd9000, 15'd20000},
		'{15'd600, 15'd1500, 15'd2000, 15'd9000, 15'd20000},
		'{15'd600, 15'd2000, 15'd2000, 15'd9000, 15'd20000}
	};

	localparam logic [1:0] BUDGET [3][5] = '{
		'{2'd2, 2'd1, 2'd1, 2'd1, 2'd1},
		'{2'd2, 2'd2, 2'd2, 2'd2, 2'd2},
		'{2'd3, 2'd3, 2'd3, 2'd3, 2'd3}
	};

	function automatic logic [1:0] eff_cond(input logic [1:0] cond);
		return (cond > NET_COND_MAX) ? NET_COND_MAX : cond;
	endfunction

	function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] cnt);
		logic [COUNT_W-1:0] n;
		n = cnt;
		if (n < COUNT_W'(1))
			n = COUNT_W'(1);
		if (n > COUNT_W'(MAX_STEPS))
			n = COUNT_W'(MAX_STEPS);
		return n;
	endfunction

	function automatic logic [2:0] level_of(input logic [LEVELS_W-1:0] levels,
	                                        input logic [STEP_W-1:0] step);
		logic [2:0] lv;
		lv = levels[3*step +: 3];
		return (lv > LEVEL_MAX) ? LEVEL_MAX : lv;
	endfunction

endpackage

/* rtl/stsq_cmd_if.sv */
// ----------------------------------------------------------------------------
// stsq_cmd_if
// Input item channel: mode, time stamp and step handler reply.
// ----------------------------------------------------------------------------
interface stsq_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] now_ms;
	logic [2:0]  reply_kind;
	logic [6:0]  reply_target;

	modport source(output valid, output mode, output now_ms, output reply_kind,
	               output reply_target, input ready);
	modport sink(input valid, input mode, input now_ms, input reply_kind,
	             input reply_target, output ready);
endinterface

/* rtl/stsq_rsp_if.sv */
// ----------------------------------------------------------------------------
// stsq_rsp_if
// Result item channel: phase, step in force and sequence status flags.
// ----------------------------------------------------------------------------
interface stsq_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] phase;
	logic [2:0] current_step;
	logic       active;
	logic       finished;
	logic       bad_reply;

	modport source(output valid, output phase, output current_step, output active,
	               output finished, output bad_reply, input ready);
	modport sink(input valid, input phase, input current_step, input active,
	             input finished, input bad_reply, output ready);
endinterface

/* rtl/stsq_core.sv */
// ----------------------------------------------------------------------------
// stsq_core
// Sequencer state and its combinational next-state update for one item.
// ----------------------------------------------------------------------------
module stsq_core
	import stsq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t result
);

	logic              running_q,       running_d;
	logic [STEP_W-1:0] step_now_q,      step_now_d;
	logic [31:0]       start_time_q,    start_time_d;
	logic [1:0]        retries_q,       retries_d;
	logic              first_pending_q, first_pending_d;
	logic [1:0]        last_phase_q,    last_phase_d;

	logic [1:0]         cond;
	logic [COUNT_W-1:0] n;
	logic [WAIT_W-1:0]  wait_now;
	logic [31:0]        elapsed;
	logic [1:0]         phase;
	logic               finished;
	logic               bad;
	logic               enter;
	logic               advance;

	assign cond     = eff_cond(cfg.net_condition);
	assign n        = eff_count(cfg.step_count);
	assign wait_now = WAIT_MS[cond][level_of(cfg.step_levels, step_now_q)];
	assign elapsed  = item.now_ms - start_time_q;

	always_comb begin
		running_d       = running_q;
		step_now_d      = step_now_q;
		start_time_d    = start_time_q;
		retries_d       = retries_q;
		first_pending_d = first_pending_q;
		last_phase_d    = last_phase_q;
		phase           = PH_NORMAL;
		finished        = 1'b0;
		bad             = 1'b0;
		enter           = 1'b0;
		advance         = 1'b0;

		unique case (item.mode)
			MODE_START: begin
				running_d  = 1'b1;
				step_now_d = '0;
				enter      = 1'b1;
			end
			MODE_TICK: begin
				if (running_q) begin
					priority if (first_pending_q) begin
						first_pending_d = 1'b0;
						phase           = PH_FIRST;
					end else if (item.now_ms < start_time_q) begin
						// clock went backwards: restart the timer
						start_time_d = item.now_ms;
					end else if (elapsed > {{(32-WAIT_W){1'b0}}, wait_now}) begin
						if (retries_q == 2'd0) begin
							phase = PH_LAST;
						end else begin
							retries_d    = retries_q - 2'd1;
							start_time_d = item.now_ms;
							phase        = PH_OVERTIME;
						end
					end else begin
						// still inside the interval: phase stays normal
					end
					last_phase_d = phase;
				end
			end
			MODE_REPLY: begin
				if (running_q) begin
					unique case (item.reply_kind)
						REPLY_JUMP: begin
							if (item.reply_target < {3'b0, n}) begin
								step_now_d = item.reply_target[STEP_W-1:0];
								enter      = 1'b1;
							end else begin
								advance = 1'b1;
							end
						end
						REPLY_DONE:  advance = 1'b1;
						REPLY_GO_ON: advance = (last_phase_q == PH_LAST);
						REPLY_REDO:  enter = 1'b1;
						REPLY_ABORT: begin
							running_d = 1'b0;
							finished  = 1'b1;
						end
						default: bad = 1'b1;
					endcase
					if (advance) begin
						if ({1'b0, step_now_q} + 4'd1 >= n) begin
							running_d = 1'b0;
							finished  = 1'b1;
						end else begin
							step_now_d = step_now_q + STEP_W'(1);
							enter      = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		// enter the step now selected: restart timer, reload retry budget
		if (enter) begin
			start_time_d    = item.now_ms;
			retries_d       = BUDGET[cond][level_of(cfg.step_levels, step_now_d)];
			first_pending_d = 1'b1;
			last_phase_d    = PH_NORMAL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q       <= 1'b0;
			step_now_q      <= '0;
			start_time_q    <= '0;
			retries_q       <= '0;
			first_pending_q <= 1'b0;
			last_phase_q    <= PH_NORMAL;
		end else if (en) begin
			running_q       <= running_d;
			step_now_q      <= step_now_d;
			start_time_q    <= start_time_d;
			retries_q       <= retries_d;
			first_pending_q <= first_pending_d;
			last_phase_q    <= last_phase_d;
		end
	end

	assign result.phase        = phase;
	assign result.current_step = step_now_d;
	assign result.active       = running_d;
	assign result.finished     = finished;
	assign result.bad_reply    = bad;

endmodule

/* rtl/step_timeout_retry_sequencer.sv */
// An item waits in the input register, its result in the result register.
// Throughput: one item per cycle while the result side takes results.
// Backpressure on the result side stalls the input register; no item is lost.
// Reset (arst_n low, asynchronous): sequence idle, step 0, timers cleared,
// net_condition 0, step_count 1, step_levels 0, both stages empty.
// ----------------------------------------------------------------------------
// step_timeout_retry_sequencer
// Protocol step sequencer with per-step wait intervals and retry budgets.
// ----------------------------------------------------------------------------
module step_timeout_retry_sequencer
	import stsq_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	stsq_cmd_if.sink              cmd,
	stsq_rsp_if.source            rsp
);

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    adv_s2;
	logic    adv_s1;

	// Configuration: a write of condition 3 is dropped, other indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.net_condition <= 2'd0;
			cfg_q.step_count    <= COUNT_W'(1);
			cfg_q.step_levels   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_NET_CONDITION: begin
					if (cfg_wdata[1:0] <= NET_COND_MAX)
						cfg_q.net_condition <= cfg_wdata[1:0];
				end
				CFG_STEP_COUNT:  cfg_q.step_count  <= cfg_wdata[COUNT_W-1:0];
				CFG_STEP_LEVELS: cfg_q.step_levels <= cfg_wdata[LEVELS_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the result register frees when empty or taken; the input
	// register moves into it whenever it frees, so both advance while results are taken
	assign adv_s2    = !valid_s2 || rsp.ready;
	assign adv_s1    = valid_s1 && adv_s2;
	assign cmd.ready = !valid_s1 || adv_s2;

	// Input register: hold the accepted item until the core consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			item_s1.mode         <= cmd.mode;
			item_s1.now_ms       <= cmd.now_ms;
			item_s1.reply_kind   <= cmd.reply_kind;
			item_s1.reply_target <= cmd.reply_target;
		end
	end

	// State and update logic; state advances only when the item moves on
	stsq_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			result_s2 <= result;
	end

	assign rsp.valid        = valid_s2;
	assign rsp.phase        = result_s2.phase;
	assign rsp.current_step = result_s2.current_step;
	assign rsp.active       = result_s2.active;
	assign rsp.finished     = result_s2.finished;
	assign rsp.bad_reply    = result_s2.bad_reply;

`ifndef SYNTH
	// input side stalls only when both stages are full and the result is held
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && valid_s2 && !rsp.ready))
		else $error("input stalled without a held result");

	// a new result appears only from an item that sat in the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s2) |-> $past(valid_s1))
		else $error("result without a source item");

	// a sequence that ended with this item is no longer running
	a_finish_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.finished) |-> !rsp.active)
		else $error("finished while still active");

	// an unknown verdict changes nothing, so it can neither finish nor tick
	a_bad_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.bad_reply) |-> (!rsp.finished && rsp.phase == PH_NORMAL))
		else $error("bad reply with side effects");
`endif

endmodule

/* tb/step_timeout_retry_sequencer_tb.sv */
// ----------------------------------------------------------------------------
// step_timeout_retry_sequencer_tb
// Drives start, tick and reply items into the step sequencer over the command
// channel and checks every status item on the result channel against a
// cycle-free model of the sequencer kept in this file. Directed items walk
// the corner cases of a step's life, then register extremes, a run that waits
// for each status item before the next counted command, and long random sequences
// with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module step_timeout_retry_sequencer_tb;
	import stsq_pkg::*;

	localparam int MAX_IDLE        = 13;
	localparam int SETTLE_CYCLES   = 6;
	localparam int QUIET_LIMIT     = 2000;
	localparam int RANDOM_PHASES   = 12;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int TARGET_MAX      = 127;
	localparam int REPORT_CAP      = 40;

	// Codes the package leaves unnamed
	localparam logic [1:0] MODE_UNUSED  = 2'd3;
	localparam logic [2:0] REPLY_BAD_LO = 3'd5;
	localparam logic [2:0] REPLY_BAD_MID = 3'd6;
	localparam logic [2:0] REPLY_BAD_HI = 3'd7;
	localparam logic [1:0] COND_INVALID = 2'd3;

	// Wait interval in ms and retry budget, by network row and wait level
	localparam int unsigned TIMEOUT_MS [3][5] = '{
		'{600, 1000, 1500, 9000, 20000},
		'{600, 1500, 2000, 9000, 20000},
		'{600, 2000, 2000, 9000, 20000}
	};
	localparam logic [1:0] RETRY_LIMIT [3][5] = '{
		'{2'd2, 2'd1, 2'd1, 2'd1, 2'd1},
		'{2'd2, 2'd2, 2'd2, 2'd2, 2'd2},
		'{2'd3, 2'd3, 2'd3, 2'd3, 2'd3}
	};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	stsq_cmd_if cmd_ch();
	stsq_rsp_if rsp_ch();

	step_timeout_retry_sequencer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd_ch),
		.rsp       (rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Register copies as the block should hold them
	logic [1:0]          cond_reg   = 2'd0;
	logic [COUNT_W-1:0]  count_reg  = 4'd1;
	logic [LEVELS_W-1:0] levels_reg = '0;

	// Sequence state as the block should hold it
	logic        seq_running    = 1'b0;
	logic [2:0]  seq_step       = 3'd0;
	logic [31:0] seq_start_ms   = 32'd0;
	logic [1:0]  seq_retries    = 2'd0;
	logic        seq_first      = 1'b0;
	phase_t      seq_last_phase = PH_NORMAL;

	result_t     status_due[$];
	logic [31:0] clock_ms    = 32'd0;
	bit          cmd_steady  = 1'b0;
	bit          rsp_steady  = 1'b0;
	int          mismatches  = 0;
	int          results_seen = 0;
	int          quiet_cycles = 0;

	function automatic int cond_row();
		return (cond_reg > 2'd2) ? 2 : int'(cond_reg);
	endfunction

	// Zero steps behaves as one, anything past the maximum as the maximum
	function automatic logic [COUNT_W-1:0] steps_in_use();
		if (count_reg == '0)
			return COUNT_W'(1);
		if (int'(count_reg) > MAX_STEPS)
			return COUNT_W'(MAX_STEPS);
		return count_reg;
	endfunction

	// Levels above four saturate
	function automatic int wait_level(input logic [2:0] step);
		logic [2:0] lv;
		lv = levels_reg[3 * step +: 3];
		return (lv > 3'd4) ? 4 : int'(lv);
	endfunction

	function automatic void enter_step(input logic [31:0] now);
		seq_start_ms   = now;
		seq_retries    = RETRY_LIMIT[cond_row()][wait_level(seq_step)];
		seq_first      = 1'b1;
		seq_last_phase = PH_NORMAL;
	endfunction

	// Apply one command item to the sequence state and return its status item
	function automatic result_t step_status_after(input item_t it);
		result_t st;
		phase_t ph;
		logic advance;
		logic done;
		logic bad;
		logic [COUNT_W-1:0] n;
		ph = PH_NORMAL;
		advance = 1'b0;
		done = 1'b0;
		bad = 1'b0;
		n = steps_in_use();
		if (it.mode == MODE_START) begin
			seq_running = 1'b1;
			seq_step = 3'd0;
			enter_step(it.now_ms);
		end else if (it.mode == MODE_TICK && seq_running) begin
			if (seq_first) begin
				seq_first = 1'b0;
				ph = PH_FIRST;
			end else if (it.now_ms < seq_start_ms) begin
				// time went backwards: restart the timer
				seq_start_ms = it.now_ms;
			end else if (it.now_ms - seq_start_ms > TIMEOUT_MS[cond_row()][wait_level(seq_step)]) begin
				if (seq_retries == 2'd0) begin
					ph = PH_LAST;
				end else begin
					seq_retries = seq_retries - 2'd1;
					seq_start_ms = it.now_ms;
					ph = PH_OVERTIME;
				end
			end
			seq_last_phase = ph;
		end else if (it.mode == MODE_REPLY && seq_running) begin
			case (it.reply_kind)
				REPLY_JUMP: begin
					if (int'(it.reply_target) < int'(n)) begin
						seq_step = it.reply_target[2:0];
						enter_step(it.now_ms);
					end else begin
						advance = 1'b1;
					end
				end
				REPLY_DONE: advance = 1'b1;
				REPLY_GO_ON: advance = (seq_last_phase == PH_LAST);
				REPLY_REDO: enter_step(it.now_ms);
				REPLY_ABORT: begin
					seq_running = 1'b0;
					done = 1'b1;
				end
				default: bad = 1'b1;
			endcase
			if (advance) begin
				if (int'(seq_step) + 1 >= int'(n)) begin
					seq_running = 1'b0;
					done = 1'b1;
				end else begin
					seq_step = seq_step + 3'd1;
					enter_step(it.now_ms);
				end
			end
		end
		st.phase        = ph;
		st.current_step = seq_step;
		st.active       = seq_running;
		st.finished     = done;
		st.bad_reply    = bad;
		return st;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= REPORT_CAP)
			$display("MISMATCH: %s", msg);
	endtask

	// Send one command item; the status it should produce is queued at acceptance
	task automatic send_item(input logic [1:0] mode, input logic [31:0] now,
	                         input logic [2:0] kind, input logic [6:0] target);
		int gap;
		item_t it;
		gap = cmd_steady ? 0 : $urandom_range(0, MAX_IDLE);
		it.mode = mode;
		it.now_ms = now;
		it.reply_kind = kind;
		it.reply_target = target;
		if (gap > 0) begin
			@(negedge clk);
			cmd_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		cmd_ch.valid        <= 1'b1;
		cmd_ch.mode         <= mode;
		cmd_ch.now_ms       <= now;
		cmd_ch.reply_kind   <= kind;
		cmd_ch.reply_target <= target;
		do @(posedge clk); while (!cmd_ch.ready);
		status_due.push_back(step_status_after(it));
	endtask

	// Hold off commands until every status item is back and the pipe is empty
	task automatic drain_results();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
	                              input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_NET_CONDITION: begin
				// an out-of-range row is dropped
				if (value[1:0] != COND_INVALID)
					cond_reg = value[1:0];
			end
			CFG_STEP_COUNT: count_reg = value[COUNT_W-1:0];
			CFG_STEP_LEVELS: levels_reg = value[LEVELS_W-1:0];
			default: ;
		endcase
	endtask

	// Random commands that mostly follow a live sequence; ignored items do not count
	task automatic run_random(input int n_items);
		int counted;
		int r;
		logic [1:0] mode;
		logic [2:0] kind;
		logic [6:0] target;
		logic [COUNT_W-1:0] n;
		counted = 0;
		while (counted < n_items) begin
			// advance the millisecond clock: mostly forward, sometimes back or anywhere
			r = $urandom_range(0, 99);
			if (r < 3)
				clock_ms = $urandom;
			else if (r < 8)
				clock_ms = clock_ms - $urandom_range(1, 3000);
			else if (r < 40)
				clock_ms = clock_ms + $urandom_range(0, 700);
			else if (r < 75)
				clock_ms = clock_ms + $urandom_range(0, 2500);
			else
				clock_ms = clock_ms + $urandom_range(0, 25000);

			r = $urandom_range(0, 99);
			if (!seq_running) begin
				if (r < 75)      mode = MODE_START;
				else if (r < 85) mode = MODE_TICK;
				else if (r < 95) mode = MODE_REPLY;
				else             mode = MODE_UNUSED;
			end else begin
				if (r < 3)       mode = MODE_START;
				else if (r < 5)  mode = MODE_UNUSED;
				else if (r < 58) mode = MODE_TICK;
				else             mode = MODE_REPLY;
			end

			r = $urandom_range(0, 99);
			if (r < 18)      kind = REPLY_JUMP;
			else if (r < 35) kind = REPLY_DONE;
			else if (r < 63) kind = REPLY_GO_ON;
			else if (r < 75) kind = REPLY_REDO;
			else if (r < 83) kind = REPLY_ABORT;
			else             kind = 3'($urandom_range(REPLY_BAD_LO, REPLY_BAD_HI));

			n = steps_in_use();
			if ($urandom_range(0, 4) != 0)
				target = 7'($urandom_range(0, int'(n) - 1));
			else
				target = 7'($urandom_range(0, TARGET_MAX));

			if (mode == MODE_START || (seq_running && mode != MODE_UNUSED))
				counted++;
			send_item(mode, clock_ms, kind, target);
		end
	endtask

	// Walk one sequence through every phase and verdict by hand
	task automatic test_directed_steps();
		drain_results();
		write_register(CFG_NET_CONDITION, 24'd0);
		write_register(CFG_STEP_COUNT, 24'd3);
		// step 0 level 0, step 1 level 1, step 2 out-of-range level
		write_register(CFG_STEP_LEVELS, 24'({3'd7, 3'd1, 3'd0}));
		// idle block: tick, reply and unused mode change nothing
		send_item(MODE_TICK, 32'd0, REPLY_JUMP, 7'd0);
		send_item(MODE_REPLY, 32'd0, REPLY_BAD_HI, 7'd127);
		send_item(MODE_UNUSED, 32'hFFFF_FFFF, REPLY_DONE, 7'd0);
		send_item(MODE_START, 32'd1000, REPLY_JUMP, 7'd0);
		// go on before any tick acts as after a normal phase
		send_item(MODE_REPLY, 32'd1000, REPLY_GO_ON, 7'd0);
		send_item(MODE_TICK, 32'd1100, REPLY_JUMP, 7'd0);
		send_item(MODE_TICK, 32'd1600, REPLY_JUMP, 7'd0);
		// clock went backwards: timer restarts
		send_item(MODE_TICK, 32'd500, REPLY_JUMP, 7'd0);
		// run out both retries, then report last
		send_item(MODE_TICK, 32'd1101, REPLY_JUMP, 7'd0);
		send_item(MODE_TICK, 32'd1702, REPLY_JUMP, 7'd0);
		send_item(MODE_TICK, 32'd2303, REPLY_JUMP, 7'd0);
		send_item(MODE_REPLY, 32'd2400, REPLY_GO_ON, 7'd0);
		send_item(MODE_REPLY, 32'd2500, REPLY_BAD_LO, 7'd1);
		send_item(MODE_REPLY, 32'd2500, REPLY_BAD_MID, 7'd2);
		send_item(MODE_REPLY, 32'd2600, REPLY_GO_ON, 7'd0);
		send_item(MODE_REPLY, 32'd2700, REPLY_REDO, 7'd0);
		send_item(MODE_REPLY, 32'd2800, REPLY_JUMP, 7'd2);
		// jump past the last step finishes the sequence
		send_item(MODE_REPLY, 32'd2900, REPLY_JUMP, 7'd127);
		send_item(MODE_START, 32'hFFFF_FFFF, REPLY_JUMP, 7'd0);
		send_item(MODE_TICK, 32'hFFFF_FFFF, REPLY_JUMP, 7'd0);
		send_item(MODE_TICK, 32'd0, REPLY_JUMP, 7'd0);
		// start while running restarts at step 0
		send_item(MODE_START, 32'd0, REPLY_JUMP, 7'd0);
		send_item(MODE_REPLY, 32'd10, REPLY_JUMP, 7'd0);
		send_item(MODE_REPLY, 32'd20, REPLY_DONE, 7'd0);
		send_item(MODE_REPLY, 32'd30, REPLY_ABORT, 7'd0);
	endtask

	// Run short sequences at the register extremes, including dropped and clamped values
	task automatic test_register_extremes();
		drain_results();
		write_register(CFG_NET_CONDITION, 24'd2);
		write_register(CFG_STEP_COUNT, 24'(MAX_STEPS));
		write_register(CFG_STEP_LEVELS, 24'd0);
		clock_ms = $urandom;
		run_random(20);
		drain_results();
		write_register(CFG_NET_CONDITION, 24'(COND_INVALID));
		write_register(CFG_STEP_COUNT, 24'hF);
		write_register(CFG_STEP_LEVELS, 24'hFF_FFFF);
		run_random(20);
		drain_results();
		write_register(CFG_NET_CONDITION, 24'd0);
		write_register(CFG_STEP_COUNT, 24'd0);
		run_random(20);
		drain_results();
		write_register(CFG_NET_CONDITION, 24'd1);
		write_register(CFG_STEP_COUNT, 24'd1);
		write_register(CFG_STEP_LEVELS, 24'($urandom));
		run_random(20);
	endtask

	// Wait for every status item before each next counted command
	task automatic test_drained_steps();
		drain_results();
		write_register(CFG_NET_CONDITION, 24'd1);
		write_register(CFG_STEP_COUNT, 24'd4);
		write_register(CFG_STEP_LEVELS, 24'($urandom));
		clock_ms = $urandom;
		send_item(MODE_START, clock_ms, REPLY_JUMP, 7'd0);
		repeat (20) begin
			run_random(1);
			drain_results();
		end
	endtask

	// Long random runs; before each phase each register may be rewritten at random
	task automatic test_random_sequences();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			drain_results();
			if ($urandom_range(0, 9) < 7)
				write_register(CFG_NET_CONDITION, 24'($urandom_range(0, 3)));
			if ($urandom_range(0, 9) < 7) begin
				if ($urandom_range(0, 4) != 0)
					write_register(CFG_STEP_COUNT, 24'($urandom_range(1, MAX_STEPS)));
				else
					write_register(CFG_STEP_COUNT, 24'($urandom_range(0, 15)));
			end
			if ($urandom_range(0, 9) < 7)
				write_register(CFG_STEP_LEVELS, 24'($urandom));
			clock_ms = $urandom;
			// some phases send back to back
			cmd_steady = ($urandom_range(0, 3) == 0);
			run_random(ITEMS_PER_PHASE);
		end
		cmd_steady = 1'b0;
	endtask

	// Result side: hold ready low for a random idle gap before taking each item
	initial begin
		int stall;
		int taken;
		taken = 0;
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rsp_steady ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				@(negedge clk);
				rsp_ch.ready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			taken++;
			// switch between stalling and streaming now and then
			if (taken % 64 == 0)
				rsp_steady = ($urandom_range(0, 2) == 0);
		end
	end

	// Compare each accepted status item with the oldest one outstanding
	always @(posedge clk) begin
		result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (status_due.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing outstanding",
				                          results_seen));
			end else begin
				want = status_due.pop_front();
				if (rsp_ch.phase !== want.phase)
					report_mismatch($sformatf("result %0d phase: got %0d, expected %0d",
					                          results_seen, rsp_ch.phase, want.phase));
				if (rsp_ch.current_step !== want.current_step)
					report_mismatch($sformatf("result %0d step: got %0d, expected %0d",
					                          results_seen, rsp_ch.current_step,
					                          want.current_step));
				if (rsp_ch.active !== want.active)
					report_mismatch($sformatf("result %0d active: got %0d, expected %0d",
					                          results_seen, rsp_ch.active, want.active));
				if (rsp_ch.finished !== want.finished)
					report_mismatch($sformatf("result %0d finished: got %0d, expected %0d",
					                          results_seen, rsp_ch.finished, want.finished));
				if (rsp_ch.bad_reply !== want.bad_reply)
					report_mismatch($sformatf("result %0d bad_reply: got %0d, expected %0d",
					                          results_seen, rsp_ch.bad_reply, want.bad_reply));
			end
			results_seen++;
		end
	end

	// Watchdog: end the run when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("step_timeout_retry_sequencer_tb failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_index           = '0;
		cfg_wdata           = '0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.mode         = MODE_START;
		cmd_ch.now_ms       = '0;
		cmd_ch.reply_kind   = REPLY_JUMP;
		cmd_ch.reply_target = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_steps();
		test_register_extremes();
		test_drained_steps();
		test_random_sequences();

		// let the last status items come back, then let the pipe settle
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("step_timeout_retry_sequencer_tb passed");
		else
			$display("step_timeout_retry_sequencer_tb failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/stsq_pkg.sv
rtl/stsq_cmd_if.sv
rtl/stsq_rsp_if.sv
rtl/stsq_core.sv
rtl/step_timeout_retry_sequencer.sv
tb/step_timeout_retry_sequencer_tb.sv
